[rtl/pcf_pkg.sv]
// Shared widths, register indexes and types for the palette color crossfader.
package pcf_pkg;

  localparam int COLOR_W    = 24;
  localparam int CH_W       = 8;
  localparam int CNT_W      = 3;
  localparam int PERIOD_W   = 16;
  localparam int ADV_W      = 16;
  localparam int ELAPSED_W  = 17;
  localparam int NUM_W      = COLOR_W;
  localparam int PAL_IDX_W  = 3;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = COLOR_W;

  // register indexes (colors occupy 0 .. PALETTE_SIZE-1)
  localparam logic [REG_IDX_W-1:0] REG_COUNT  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD = 3'd7;

  localparam logic [CNT_W-1:0]    RESET_COUNT  = 3'd1;
  localparam logic [PERIOD_W-1:0] RESET_PERIOD = 16'd1000;

  typedef struct packed {
    logic [CNT_W-1:0]    count;     // effective entry count, 1..PALETTE_SIZE
    logic [PERIOD_W-1:0] period;    // raw period, may be zero
    logic                count_wr;  // pulses in the cycle after a count write
  } pcf_cfg_t;

endpackage

[rtl/pcf_regs.sv]
// Configuration register file: palette entries, entry count and fade period.
module pcf_regs #(
  parameter int PALETTE_SIZE = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pcf_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [pcf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [$clog2(PALETTE_SIZE)-1:0]     rd_idx,
  output logic [pcf_pkg::COLOR_W-1:0]         rd_color,
  output pcf_pkg::pcf_cfg_t                   cfg
);
  import pcf_pkg::*;

  logic [COLOR_W-1:0]  color [PALETTE_SIZE];
  logic [CNT_W-1:0]    count_raw;
  logic [CNT_W-1:0]    count_eff;
  logic [PERIOD_W-1:0] period;
  logic                count_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PALETTE_SIZE; i++) begin
        color[i] <= '0;
      end
      count_raw <= RESET_COUNT;
      period    <= RESET_PERIOD;
      count_wr  <= 1'b0;
    end else begin
      count_wr <= cfg_we && (cfg_index == REG_COUNT);
      if (cfg_we) begin
        for (int i = 0; i < PALETTE_SIZE; i++) begin
          if (cfg_index == REG_IDX_W'(i)) begin
            color[i] <= cfg_data[COLOR_W-1:0];
          end
        end
        if (cfg_index == REG_COUNT) begin
          count_raw <= cfg_data[CNT_W-1:0];
        end
        if (cfg_index == REG_PERIOD) begin
          period <= cfg_data[PERIOD_W-1:0];
        end
      end
    end
  end

  // zero acts as one, anything above the palette size is clipped
  always_comb begin
    if (count_raw == '0) begin
      count_eff = CNT_W'(1);
    end else if (count_raw > CNT_W'(PALETTE_SIZE)) begin
      count_eff = CNT_W'(PALETTE_SIZE);
    end else begin
      count_eff = count_raw;
    end
  end

  assign rd_color     = color[rd_idx];
  assign cfg.count    = count_eff;
  assign cfg.period   = period;
  assign cfg.count_wr = count_wr;

endmodule

[rtl/pcf_div.sv]
// Restoring divider, one quotient bit per cycle; quotient known to fit CH_W bits.
module pcf_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pcf_pkg::NUM_W-1:0]     dividend,
  input  logic [pcf_pkg::PERIOD_W-1:0]  divisor,
  output logic                          done,
  output logic [pcf_pkg::CH_W-1:0]      quotient
);
  import pcf_pkg::*;

  localparam int REM_W = NUM_W - CH_W;
  localparam int CNT_BITS = $clog2(CH_W);

  logic                busy;
  logic [CNT_BITS-1:0] step;
  logic [REM_W-1:0]    rem;
  logic [CH_W-1:0]     lo;     // dividend bits shift out, quotient bits shift in
  logic [PERIOD_W-1:0] dvs;
  logic [REM_W:0]      rem_sh;
  logic                ge;

  assign rem_sh = {rem, lo[CH_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == CNT_BITS'(CH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // top bits of the dividend are below the divisor, so the remainder fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[NUM_W-1:CH_W];
      lo  <= dividend[CH_W-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? REM_W'(rem_sh - {1'b0, dvs}) : rem_sh[REM_W-1:0];
      lo  <= {lo[CH_W-2:0], ge};
    end
  end

  assign quotient = lo;

endmodule

[rtl/palette_color_crossfader_top.sv]
// Palette color crossfader: linear RGB fade between successive palette entries.
// Blend beat: after the input beat the sequencer steps through LOAD, then per
//   channel MUL_A and MUL_B on the shared multiplier and DIV on the shared
//   one-bit-per-cycle divider, channels done red, green, blue, then DONE.
// Switch beat (counter past the period): straight to DONE; next input only in IDLE.
// Synchronous active-high reset clears palette to 0, count to 1, period to 1000,
//   index and tick counter to 0; no clearing pass, ready right after reset.
module palette_color_crossfader_top #(
  parameter int PALETTE_SIZE = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pcf_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [pcf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pcf_pkg::ADV_W-1:0]       advance,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pcf_pkg::CH_W-1:0]        red,
  output logic [pcf_pkg::CH_W-1:0]        green,
  output logic [pcf_pkg::CH_W-1:0]        blue,
  output logic [pcf_pkg::PAL_IDX_W-1:0]   palette_index,
  output logic                            switched
);
  import pcf_pkg::*;

  localparam int IDX_W = $clog2(PALETTE_SIZE);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_MUL_A = 3'd2;
  localparam logic [2:0] S_MUL_B = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  pcf_cfg_t             cfg;
  logic [IDX_W-1:0]     rd_idx;
  logic [COLOR_W-1:0]   rd_color;

  logic [2:0]           state;
  logic [IDX_W-1:0]     entry_index;
  logic [ELAPSED_W-1:0] elapsed_ticks;
  logic [1:0]           chan;

  // per-item working registers
  logic [COLOR_W-1:0]   cur_rgb;
  logic [COLOR_W-1:0]   nxt_rgb;
  logic [COLOR_W-1:0]   rgb_acc;
  logic [PERIOD_W-1:0]  p_eff;
  logic [PERIOD_W-1:0]  weight;
  logic [NUM_W-1:0]     acc;
  logic                 sw_flag;

  logic                 accept;
  logic [IDX_W-1:0]     idx_clamped;
  logic [CNT_W-1:0]     idx_inc;
  logic [IDX_W-1:0]     nxt_idx;
  logic [ELAPSED_W:0]   tick_sum;
  logic [ELAPSED_W-1:0] e_sat;
  logic                 do_switch;

  logic [CH_W-1:0]      cur_ch;
  logic [CH_W-1:0]      nxt_ch;
  logic [CH_W-1:0]      mul_a;
  logic [PERIOD_W-1:0]  mul_b;
  logic [NUM_W-1:0]     product;

  logic                 div_start;
  logic [NUM_W-1:0]     div_dividend;
  logic                 div_done;
  logic [CH_W-1:0]      div_q;

  pcf_regs #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_idx    (rd_idx),
    .rd_color  (rd_color),
    .cfg       (cfg)
  );

  pcf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (p_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  // Input side is open only in IDLE; a waiting result does not block it.
  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;

  // Current index, re-checked against the effective count, and its successor.
  assign idx_clamped = (CNT_W'(entry_index) >= cfg.count) ? '0 : entry_index;
  assign idx_inc     = CNT_W'(idx_clamped) + CNT_W'(1);
  assign nxt_idx     = (idx_inc < cfg.count) ? idx_inc[IDX_W-1:0] : '0;

  // Saturating tick counter; a zero period switches on any nonzero count.
  assign tick_sum  = {1'b0, elapsed_ticks} + (ELAPSED_W + 1)'(advance);
  assign e_sat     = tick_sum[ELAPSED_W] ? '1 : tick_sum[ELAPSED_W-1:0];
  assign do_switch = e_sat > ELAPSED_W'(cfg.period);

  // Single palette read port: next entry on the input beat, current entry after.
  assign rd_idx = (state == S_IDLE) ? nxt_idx : entry_index;

  always_comb begin
    case (chan)
      CH_RED: begin
        cur_ch = cur_rgb[23:16];
        nxt_ch = nxt_rgb[23:16];
      end
      CH_GREEN: begin
        cur_ch = cur_rgb[15:8];
        nxt_ch = nxt_rgb[15:8];
      end
      default: begin
        cur_ch = cur_rgb[7:0];
        nxt_ch = nxt_rgb[7:0];
      end
    endcase
  end

  // Shared multiplier: cur*(p-w) first, then next*w added on the way to the divider.
  // The sum is at most 255*p, so it fits NUM_W bits and the quotient fits a byte.
  assign mul_a        = (state == S_MUL_A) ? cur_ch : nxt_ch;
  assign mul_b        = (state == S_MUL_A) ? (p_eff - weight) : weight;
  assign product      = mul_a * mul_b;
  assign div_start    = (state == S_MUL_B);
  assign div_dividend = acc + product;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_index   <= '0;
      elapsed_ticks <= '0;
      chan          <= CH_RED;
      out_valid     <= 1'b0;
    end else begin
      // result register: loads from DONE, empties when taken
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (do_switch) begin
              entry_index   <= nxt_idx;
              elapsed_ticks <= '0;
              state         <= S_DONE;
            end else begin
              entry_index   <= idx_clamped;
              elapsed_ticks <= e_sat;
              chan          <= CH_RED;
              state         <= S_LOAD;
            end
          end else if (cfg.count_wr && (CNT_W'(entry_index) >= cfg.count)) begin
            // count write while idle: pull the index back into range
            entry_index <= '0;
          end
        end
        S_LOAD: begin
          state <= S_MUL_A;
        end
        S_MUL_A: begin
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (chan == CH_BLUE) begin
              state <= S_DONE;
            end else begin
              chan  <= chan + 2'd1;
              state <= S_MUL_A;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath and output register
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          sw_flag <= do_switch;
          if (do_switch) begin
            rgb_acc <= rd_color;   // new entry goes out unblended
          end else begin
            nxt_rgb <= rd_color;
            weight  <= e_sat[PERIOD_W-1:0];
            p_eff   <= (cfg.period == '0) ? PERIOD_W'(1) : cfg.period;
          end
        end
      end
      S_LOAD: begin
        cur_rgb <= rd_color;
      end
      S_MUL_A: begin
        acc <= product;
      end
      S_DIV: begin
        if (div_done) begin
          case (chan)
            CH_RED:   rgb_acc[23:16] <= div_q;
            CH_GREEN: rgb_acc[15:8]  <= div_q;
            default:  rgb_acc[7:0]   <= div_q;
          endcase
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          red           <= rgb_acc[23:16];
          green         <= rgb_acc[15:8];
          blue          <= rgb_acc[7:0];
          palette_index <= PAL_IDX_W'(entry_index);
          switched      <= sw_flag;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/pcf_checker.sv]
// Port-level checks for the palette color crossfader, bound to the top level.
module pcf_checker #(
  parameter int PALETTE_SIZE = 6
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [pcf_pkg::CH_W-1:0]        red,
  input logic [pcf_pkg::CH_W-1:0]        green,
  input logic [pcf_pkg::CH_W-1:0]        blue,
  input logic [pcf_pkg::PAL_IDX_W-1:0]   palette_index,
  input logic                            switched
);
  import pcf_pkg::*;

  // a result beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
      && $stable(blue) && $stable(palette_index) && $stable(switched))
    else $error("result changed while stalled");

  // one item at a time: input closes right after a beat is taken
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after an accepted beat");

  // a new result only comes out of the busy phase
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> palette_index < PAL_IDX_W'(PALETTE_SIZE))
    else $error("palette index out of range");

endmodule

bind palette_color_crossfader_top pcf_checker #(
  .PALETTE_SIZE (PALETTE_SIZE)
) u_pcf_checker (.*);
